@@ design/uf_pkg.sv @@
// shared widths and types for the disjoint-set engine
// no dependencies
`default_nettype none

package uf_pkg;

    localparam int NODE_W = 10;
    localparam int NODES  = 1 << NODE_W;
    localparam int RANK_W = 4;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [RANK_W-1:0] rank_t;

    localparam node_t NODE_LAST = node_t'(NODES - 1);
    localparam rank_t RANK_MAX  = '1;

    localparam logic CMD_JOIN  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

`default_nettype wire

@@ design/union_find_engine.sv @@
// disjoint-set table with union by rank and full path compression
// parent and rank entries live in two memories with registered reads; uses uf_pkg
// an item walks its first node to the root and compresses that path, then does the same
// for the second node; a join of two distinct roots then reads both ranks and links them,
// and the result is raised in the output state, where a stalled result waits; the walk depth
// is at most log2(NODES); one item at a time, item_stall falls in the cycle the result rises
// reset runs a clearing pass over all NODES (1024) entries that restores every parent
// and rank entry; no item is taken until it ends
`default_nettype none

module union_find_engine
    import uf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire logic  cmd,
    input  wire node_t first_node,
    input  wire node_t second_node,
    output logic       result_valid,
    input  wire logic  result_stall,
    output logic       same_set
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_COMP  = 3'd3;
    localparam logic [2:0] S_RANK  = 3'd4;
    localparam logic [2:0] S_LINK  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    node_t      clr_cnt_reg, clr_cnt_next;
    node_t      cur_reg, cur_next;
    node_t      start_reg, start_next;
    node_t      nb_reg, nb_next;
    node_t      ra_reg, ra_next;
    node_t      rb_reg, rb_next;
    logic       phase_reg, phase_next;
    logic       cmd_reg, cmd_next;
    rank_t      rka_reg, rka_next;
    logic       result_valid_reg, result_valid_next;
    logic       same_set_reg, same_set_next;

    node_t      parent_mem [NODES];
    rank_t      rank_mem [NODES];
    node_t      prd_reg;
    rank_t      rrd_reg;

    node_t      pra, pwa, pwd;
    logic       pwe;
    node_t      rra, rwa;
    rank_t      rwd;
    logic       rwe;
    node_t      root;

    assign root = phase_reg ? rb_reg : ra_reg;
    assign rra  = (state_reg == S_RANK) ? rb_reg : ra_reg;

    always_ff @(posedge clk)
    begin
        if (pwe)
        begin
            parent_mem[pwa] <= pwd;
        end
        prd_reg <= parent_mem[pra];
    end

    always_ff @(posedge clk)
    begin
        if (rwe)
        begin
            rank_mem[rwa] <= rwd;
        end
        rrd_reg <= rank_mem[rra];
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        cur_next          = cur_reg;
        start_next        = start_reg;
        nb_next           = nb_reg;
        ra_next           = ra_reg;
        rb_next           = rb_reg;
        phase_next        = phase_reg;
        cmd_next          = cmd_reg;
        rka_next          = rka_reg;
        same_set_next     = same_set_reg;
        result_valid_next = result_valid_reg && result_stall;
        pra               = cur_reg;
        pwe               = 1'b0;
        pwa               = cur_reg;
        pwd               = root;
        rwe               = 1'b0;
        rwa               = ra_reg;
        rwd               = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                pwe          = 1'b1;
                pwa          = clr_cnt_reg;
                pwd          = clr_cnt_reg;
                rwe          = 1'b1;
                rwa          = clr_cnt_reg;
                rwd          = '0;
                clr_cnt_next = clr_cnt_reg + node_t'(1);
                if (clr_cnt_reg == NODE_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    pra        = first_node;
                    cur_next   = first_node;
                    start_next = first_node;
                    nb_next    = second_node;
                    cmd_next   = cmd;
                    phase_next = 1'b0;
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                if (prd_reg == cur_reg)
                begin
                    if (phase_reg)
                    begin
                        rb_next = cur_reg;
                    end
                    else
                    begin
                        ra_next = cur_reg;
                    end
                    pra        = start_reg;
                    cur_next   = start_reg;
                    state_next = S_COMP;
                end
                else
                begin
                    pra      = prd_reg;
                    cur_next = prd_reg;
                end
            end
            S_COMP:
            begin
                if (cur_reg != root)
                begin
                    pwe      = 1'b1;
                    pwa      = cur_reg;
                    pwd      = root;
                    pra      = prd_reg;
                    cur_next = prd_reg;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    pra        = nb_reg;
                    cur_next   = nb_reg;
                    start_next = nb_reg;
                    state_next = S_FIND;
                end
                else if ((cmd_reg == CMD_JOIN) && (ra_reg != rb_reg))
                begin
                    state_next = S_RANK;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_RANK:
            begin
                rka_next   = rrd_reg;
                state_next = S_LINK;
            end
            S_LINK:
            begin
                pwe = 1'b1;
                if (rka_reg < rrd_reg)
                begin
                    pwa = ra_reg;
                    pwd = rb_reg;
                end
                else
                begin
                    pwa = rb_reg;
                    pwd = ra_reg;
                    if ((rka_reg == rrd_reg) && (rka_reg != RANK_MAX))
                    begin
                        rwe = 1'b1;
                        rwa = ra_reg;
                        rwd = rka_reg + rank_t'(1);
                    end
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    same_set_next     = (ra_reg == rb_reg);
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            phase_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            phase_reg        <= phase_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        start_reg    <= start_next;
        nb_reg       <= nb_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        cmd_reg      <= cmd_next;
        rka_reg      <= rka_next;
        same_set_reg <= same_set_next;
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign same_set     = same_set_reg;

    // compression write never hits the entry read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP) && pwe |-> (pwa != pra))
        else $error("parent read and write collide during compression");

    // a link only ever hangs one root under another, never under itself
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |-> (pwa != pwd))
        else $error("link would make a self loop");

    // a new result beat only comes out of the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    // ranks are only touched by clearing or by linking two distinct roots
    assert property (@(posedge clk) disable iff (!rst_n)
        rwe |-> ((state_reg == S_CLEAR) || ((state_reg == S_LINK) && (ra_reg != rb_reg))))
        else $error("unexpected rank write");

endmodule

`default_nettype wire

@@ dv/union_find_engine_tb.sv @@
// self-checking bench for the disjoint-set engine: directed joins and queries, then random
// windowed traffic with gaps and stalls on both channels, checked by a scoreboard class
// depends on uf_pkg and union_find_engine
`default_nettype none

module union_find_engine_tb
    import uf_pkg::*;
();

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RAND_BLOCKS  = 60;
    localparam int BLOCK_ITEMS  = 30;

    class dsu_scoreboard;
        node_t parent_of [NODES];
        rank_t rank_of [NODES];
        bit    pending_same_set [$];
        int    mismatches;

        function new();
            for (int i = 0; i < NODES; i++)
            begin
                parent_of[i] = node_t'(i);
                rank_of[i]   = '0;
            end
            mismatches = 0;
        endfunction

        // walk to the root, then point the whole path at it
        function node_t find_root(node_t n);
            node_t r;
            node_t nxt;
            r = n;
            while (parent_of[r] != r)
                r = parent_of[r];
            while (n != r)
            begin
                nxt          = parent_of[n];
                parent_of[n] = r;
                n            = nxt;
            end
            return r;
        endfunction

        function void note_item(logic op, node_t a, node_t b);
            node_t ra;
            node_t rb;
            bit    same;
            ra   = find_root(a);
            rb   = find_root(b);
            same = (ra == rb);
            if (op == CMD_JOIN && !same)
            begin
                if (rank_of[ra] < rank_of[rb])
                    parent_of[ra] = rb;
                else
                begin
                    if (rank_of[ra] == rank_of[rb] && rank_of[ra] != RANK_MAX)
                        rank_of[ra] = rank_of[ra] + rank_t'(1);
                    parent_of[rb] = ra;
                end
            end
            pending_same_set.push_back(same);
        endfunction

        function void check_result(logic actual);
            bit exp_same;
            if (pending_same_set.size() == 0)
            begin
                $display("%0t: same_set expected none actual %0b", $time, actual);
                mismatches++;
            end
            else
            begin
                exp_same = pending_same_set.pop_front();
                if (actual !== exp_same)
                begin
                    $display("%0t: same_set expected %0b actual %0b", $time, exp_same, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic  clk          = 1'b0;
    logic  rst_n        = 1'b0;
    logic  item_valid   = 1'b0;
    logic  cmd          = CMD_QUERY;
    node_t first_node   = '0;
    node_t second_node  = '0;
    logic  result_stall = 1'b0;
    logic  item_stall;
    logic  result_valid;
    logic  same_set;

    dsu_scoreboard sb = new();
    int idle_cycles   = 0;
    bit sender_quiet  = 1'b0;

    union_find_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .first_node   (first_node),
        .second_node  (second_node),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .same_set     (same_set)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        if (sender_quiet)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_item(input logic op, input node_t a, input node_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid  <= 1'b1;
        cmd         <= op;
        first_node  <= a;
        second_node <= b;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(op, a, b);
        @(negedge clk);
    endtask

    initial
    begin : result_sink
        int hold;
        int quiet;
        int roll;
        hold  = 0;
        quiet = 0;
        forever
        begin
            @(negedge clk);
            if (hold == 0 && quiet == 0)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                    quiet = $urandom_range(200, 50);
                else if (roll < 13)
                    hold = $urandom_range(40, 10);
                else if (roll < 45)
                    hold = $urandom_range(3, 1);
            end
            if (hold > 0)
            begin
                hold--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (quiet > 0)
                    quiet--;
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(same_set);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL union_find_engine");
            $finish;
        end
    end

    initial
    begin : stimulus
        int    wsize;
        int    base;
        int    roll;
        logic  op;
        node_t a;
        node_t b;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // self pairs, far ends, equal and unequal ranks, joins within one set
        send_item(CMD_QUERY, 10'd0, 10'd0);
        send_item(CMD_JOIN, 10'd1023, 10'd1023);
        send_item(CMD_QUERY, 10'd0, 10'd1023);
        send_item(CMD_JOIN, 10'd0, 10'd1023);
        send_item(CMD_QUERY, 10'd1023, 10'd0);
        send_item(CMD_JOIN, 10'd0, 10'd1023);
        send_item(CMD_JOIN, 10'h155, 10'h2AA);
        send_item(CMD_JOIN, 10'd1023, 10'h155);
        send_item(CMD_JOIN, 10'd5, 10'h2AA);
        send_item(CMD_JOIN, 10'd6, 10'd7);
        send_item(CMD_JOIN, 10'd8, 10'd9);
        send_item(CMD_JOIN, 10'd6, 10'd8);
        send_item(CMD_JOIN, 10'd10, 10'd6);
        send_item(CMD_JOIN, 10'd11, 10'd12);
        send_item(CMD_JOIN, 10'd13, 10'd14);
        send_item(CMD_JOIN, 10'd11, 10'd13);
        send_item(CMD_JOIN, 10'd9, 10'd14);
        send_item(CMD_QUERY, 10'd12, 10'd7);
        send_item(CMD_JOIN, 10'd12, 10'd5);
        send_item(CMD_QUERY, 10'd10, 10'h2AA);
        send_item(CMD_QUERY, 10'd200, 10'd300);
        send_item(CMD_JOIN, 10'd12, 10'd1023);

        for (int blk = 0; blk < RAND_BLOCKS; blk++)
        begin
            roll = $urandom_range(99);
            if (roll < 40)
                wsize = 8;
            else if (roll < 75)
                wsize = 32;
            else if (roll < 90)
                wsize = 128;
            else
                wsize = NODES;
            base         = $urandom_range(NODES - wsize);
            sender_quiet = ($urandom_range(3) == 0);
            for (int k = 0; k < BLOCK_ITEMS; k++)
            begin
                op = ($urandom_range(99) < 60) ? CMD_JOIN : CMD_QUERY;
                if ($urandom_range(9) == 0)
                begin
                    a = node_t'($urandom_range(NODES - 1));
                    b = node_t'($urandom_range(NODES - 1));
                end
                else
                begin
                    a = node_t'(base + $urandom_range(wsize - 1));
                    b = node_t'(base + $urandom_range(wsize - 1));
                end
                send_item(op, a, b);
            end
        end

        item_valid <= 1'b0;
        while (sb.pending_same_set.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_same_set.size() == 0)
            $display("PASS union_find_engine");
        else
            $display("FAIL union_find_engine");
        $finish;
    end

endmodule

`default_nettype wire
